[design/ordered_stream_reorder_buffer_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the ordered stream reorder buffer
// Shared concurrent assertion forms, all clocked on the rising edge and
// disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef ORDERED_STREAM_REORDER_BUFFER_MACROS_SVH
`define ORDERED_STREAM_REORDER_BUFFER_MACROS_SVH

// Same-cycle implication
`define OSRB_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define OSRB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/osrb_pkg.sv]
// ----------------------------------------------------------------------------
// osrb_pkg
// Sizes and constants of the ordered stream reorder buffer.
// ----------------------------------------------------------------------------
package osrb_pkg;

   // Slots in the stream, slot numbers run 1 to DEPTH (slot 0 is stored too)
   localparam int DEPTH      = 64;
   // Chunk bits that are kept
   localparam int CHUNK_BITS = 64;

   // Port widths fixed by the payload
   localparam int SLOT_W  = 7;
   localparam int CHUNK_W = 64;

   // Chunk store: one entry per slot 0 .. DEPTH
   localparam int RAM_DEPTH = DEPTH + 1;
   localparam int ADDR_W    = $clog2(RAM_DEPTH);

   // Stream length after reset
   localparam int LEN_RESET = (64 > DEPTH) ? DEPTH : 64;

endpackage

[design/osrb_ram.sv]
// ----------------------------------------------------------------------------
// osrb_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered and held while no read is issued.
// ----------------------------------------------------------------------------
module osrb_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 65
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/ordered_stream_reorder_buffer.sv]
// Release: an insert that fills the gap at the pointer, or an insert out of range,
//   moves the block to the emit state, which registers each result onto rsp_valid;
//   further chunks of the run are read from the chunk store in slot order.
// Stalls: req_stall is high in the emit state, so no insert is taken until the
//   last result of a run or an error result is registered; other inserts do not stall.
// Reset: valid marks clear at once, pointer 1, stream length 64; no clearing
//   pass. The chunk store itself is not reset.
// ----------------------------------------------------------------------------
// ordered_stream_reorder_buffer
// Reorder buffer: stores chunks by slot number and releases consecutive
// valid slots in slot order from the next-expected pointer.
// ----------------------------------------------------------------------------
`include "ordered_stream_reorder_buffer_macros.svh"

module ordered_stream_reorder_buffer (
   input  logic                              clock,
   input  logic                              reset,
   // configuration
   input  logic                              csr_we,
   input  logic [osrb_pkg::SLOT_W-1:0]       csr_wdata,
   // inserts
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [osrb_pkg::SLOT_W-1:0]       req_slot_id,
   input  logic [osrb_pkg::CHUNK_W-1:0]      req_chunk,
   // released chunks
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [osrb_pkg::CHUNK_W-1:0]      rsp_chunk_out,
   output logic [osrb_pkg::SLOT_W-1:0]       rsp_slot_out,
   output logic                              rsp_run_last,
   output logic                              rsp_slot_error
);

   typedef enum logic {
      ST_IDLE,
      ST_EMIT
   } state_type;

   localparam int SW = osrb_pkg::SLOT_W;
   localparam int AW = osrb_pkg::ADDR_W;
   localparam int CB = osrb_pkg::CHUNK_BITS;
   localparam int CW = osrb_pkg::CHUNK_W;

   // Control state
   state_type                   state_ff, state_in;
   logic [osrb_pkg::DEPTH:0]    valid_ff, valid_in;
   logic [SW-1:0]               ne_ff, ne_in;
   logic [SW-1:0]               len_ff, len_in;
   logic                        out_valid_ff, out_valid_in;

   // Payload registers
   logic [CB-1:0]               hold_chunk_ff, hold_chunk_in;
   logic                        err_ff, err_in;
   logic                        sel_ram_ff, sel_ram_in;
   logic [CW-1:0]               out_chunk_ff, out_chunk_in;
   logic [SW-1:0]               out_slot_ff, out_slot_in;
   logic                        out_last_ff, out_last_in;
   logic                        out_err_ff, out_err_in;

   // Chunk store ports
   logic                        wr_en;
   logic [AW-1:0]               wr_addr;
   logic                        rd_en;
   logic [AW-1:0]               rd_addr;
   logic [CB-1:0]               rd_data;

   logic                        req_xfer;
   logic                        slot_err;
   logic                        hit;
   logic                        out_free;
   logic [SW-1:0]               nxt;
   logic                        more;
   logic [SW-1:0]               len_clamp;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign slot_err  = (req_slot_id > len_ff);
   // Only an insert at the pointer can start a run
   assign hit       = !slot_err && (req_slot_id == ne_ff);
   assign out_free  = !out_valid_ff || !rsp_stall;

   // Next slot of the run and whether it is ready
   assign nxt  = ne_ff + SW'(1);
   assign more = (nxt <= len_ff) ? valid_ff[AW'(nxt)] : 1'b0;

   // Stream length written out of range is clamped
   always_comb begin
      priority if (csr_wdata == '0) begin
         len_clamp = SW'(1);
      end else if (csr_wdata > SW'(osrb_pkg::DEPTH)) begin
         len_clamp = SW'(osrb_pkg::DEPTH);
      end else begin
         len_clamp = csr_wdata;
      end
   end

   // Store write on every insert within the stream
   assign wr_en   = req_xfer && !slot_err;
   assign wr_addr = AW'(req_slot_id);

   // Next state and datapath
   always_comb begin
      state_in      = state_ff;
      valid_in      = valid_ff;
      ne_in         = ne_ff;
      len_in        = len_ff;
      out_valid_in  = out_valid_ff && rsp_stall;
      hold_chunk_in = hold_chunk_ff;
      err_in        = err_ff;
      sel_ram_in    = sel_ram_ff;
      out_chunk_in  = out_chunk_ff;
      out_slot_in   = out_slot_ff;
      out_last_in   = out_last_ff;
      out_err_in    = out_err_ff;
      rd_en         = 1'b0;
      rd_addr       = AW'(nxt);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               hold_chunk_in = req_chunk[CB-1:0];
               err_in        = slot_err;
               sel_ram_in    = 1'b0;
               if (!slot_err) begin
                  valid_in[AW'(req_slot_id)] = 1'b1;
               end
               if (slot_err || hit) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_err_in   = err_ff;
               if (err_ff) begin
                  out_chunk_in = '0;
                  out_slot_in  = '0;
                  out_last_in  = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  out_chunk_in = CW'(sel_ram_ff ? rd_data : hold_chunk_ff);
                  out_slot_in  = ne_ff;
                  out_last_in  = !more;
                  ne_in        = nxt;
                  if (more) begin
                     // fetch the next chunk of the run
                     rd_en      = 1'b1;
                     sel_ram_in = 1'b1;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Length write restarts the stream
      if (csr_we) begin
         len_in   = len_clamp;
         valid_in = '0;
         ne_in    = SW'(1);
      end
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         ne_ff        <= SW'(1);
         len_ff       <= SW'(osrb_pkg::LEN_RESET);
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         ne_ff        <= ne_in;
         len_ff       <= len_in;
         out_valid_ff <= out_valid_in;
      end
      hold_chunk_ff <= hold_chunk_in;
      err_ff        <= err_in;
      sel_ram_ff    <= sel_ram_in;
      out_chunk_ff  <= out_chunk_in;
      out_slot_ff   <= out_slot_in;
      out_last_ff   <= out_last_in;
      out_err_ff    <= out_err_in;
   end

   // Chunk store
   osrb_ram #(
      .WIDTH (CB),
      .DEPTH (osrb_pkg::RAM_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_chunk[CB-1:0]),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid      = out_valid_ff;
   assign rsp_chunk_out  = out_chunk_ff;
   assign rsp_slot_out   = out_slot_ff;
   assign rsp_run_last   = out_last_ff;
   assign rsp_slot_error = out_err_ff;

   // Checks
   `OSRB_ASSERT_IMPLY(a_ptr_bound, clock, reset, 1'b1,
      ({1'b0, ne_ff} <= ({1'b0, len_ff} + (SW+1)'(1))), "pointer ran past stream end")
   `OSRB_ASSERT_IMPLY(a_err_shape, clock, reset, rsp_valid && rsp_slot_error,
      rsp_run_last && (rsp_slot_out == '0) && (rsp_chunk_out == '0), "bad error result")
   `OSRB_ASSERT_IMPLY(a_slot_range, clock, reset, rsp_valid && !rsp_slot_error,
      (rsp_slot_out != '0) && (rsp_slot_out <= len_ff), "released slot out of range")
   `OSRB_ASSERT_NEXT(a_hit_fwd, clock, reset, req_xfer && hit && !csr_we,
      (state_ff == ST_EMIT) && !sel_ram_ff && !err_ff, "gap fill did not start a run")

endmodule

[tb/ordered_stream_reorder_buffer_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ordered_stream_reorder_buffer_tb
// Self-checking bench for the reorder buffer. Inserts are scattered over the
// slots of short streams and a few full-length ones, mixed with stray slots.
// A scoreboard tracks the filled slots and the release pointer, predicts each
// in-order release and checks every released transfer against it.
// ----------------------------------------------------------------------------
module ordered_stream_reorder_buffer_tb;

   localparam int SW            = osrb_pkg::SLOT_W;
   localparam int CW            = osrb_pkg::CHUNK_W;
   localparam int MAX_CYCLES    = 200000;
   localparam int SETTLE_CYCLES = 6;
   localparam int TARGET_ITEMS  = 450;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_mode_type;

   typedef enum int {
      NOISE_ZERO,
      NOISE_ABOVE,
      NOISE_REPEAT,
      NOISE_ANY
   } noise_kind_type;

   // one released chunk as seen on the result port
   typedef struct {
      logic [CW-1:0] chunk;
      logic [SW-1:0] slot;
      logic          last;
      logic          err;
   } release_type;

   // ------------------------------------------------------------------------
   // Scoreboard: slot store, release pointer and the queue of due releases
   // ------------------------------------------------------------------------
   class release_scoreboard;
      logic [CW-1:0] payload_ram [0:osrb_pkg::DEPTH];
      bit            filled      [0:osrb_pkg::DEPTH];
      int unsigned   next_slot;
      int unsigned   length;
      release_type   due[$];
      int            errors;

      function new();
         length = osrb_pkg::LEN_RESET;
         errors = 0;
         restart();
      endfunction

      function void restart();
         foreach (filled[i]) filled[i] = 1'b0;
         next_slot = 1;
      endfunction

      // register write: clamp to 1 .. DEPTH, then restart the stream
      function void write_length(logic [SW-1:0] value);
         int unsigned len;
         len = 32'(value);
         if (len < 1) len = 1;
         if (len > osrb_pkg::DEPTH) len = osrb_pkg::DEPTH;
         length = len;
         restart();
      endfunction

      function void note_insert(logic [SW-1:0] slot, logic [CW-1:0] data);
         logic [CW-1:0] mask;
         release_type   r;
         bit            have;
         mask = {CW{1'b1}} >> (CW - osrb_pkg::CHUNK_BITS);
         have = 1'b0;
         // slot out of range: one error transfer, nothing stored
         if (slot > length) begin
            r.chunk = '0;
            r.slot  = '0;
            r.last  = 1'b1;
            r.err   = 1'b1;
            due = {due, r};
            return;
         end
         payload_ram[slot] = data & mask;
         filled[slot]      = 1'b1;
         // release the run of filled slots at the pointer
         while (next_slot >= 1 && next_slot <= length && filled[next_slot]) begin
            if (have) due = {due, r};
            r.chunk   = payload_ram[next_slot] & mask;
            r.slot    = next_slot[SW-1:0];
            r.last    = 1'b0;
            r.err     = 1'b0;
            have      = 1'b1;
            next_slot = (next_slot + 1) & 7'h7F;
         end
         if (have) begin
            r.last = 1'b1;
            due = {due, r};
         end
      endfunction

      function void check_result(logic [CW-1:0] chunk, logic [SW-1:0] slot,
                                 logic last, logic err);
         release_type x;
         if (due.size() == 0) begin
            $display("%0t: unexpected transfer chunk=%h slot=%0d last=%b err=%b",
                     $time, chunk, slot, last, err);
            errors++;
            return;
         end
         x = due.pop_front();
         if (chunk !== x.chunk) begin
            $display("%0t: chunk_out expected %h actual %h", $time, x.chunk, chunk);
            errors++;
         end
         if (slot !== x.slot) begin
            $display("%0t: slot_out expected %0d actual %0d", $time, x.slot, slot);
            errors++;
         end
         if (last !== x.last) begin
            $display("%0t: run_last expected %b actual %b", $time, x.last, last);
            errors++;
         end
         if (err !== x.err) begin
            $display("%0t: slot_error expected %b actual %b", $time, x.err, err);
            errors++;
         end
      endfunction
   endclass

   logic          clock;
   logic          reset;
   logic          csr_we;
   logic [SW-1:0] csr_wdata;
   logic          req_valid;
   logic          req_stall;
   logic [SW-1:0] req_slot_id;
   logic [CW-1:0] req_chunk;
   logic          rsp_valid;
   logic          rsp_stall;
   logic [CW-1:0] rsp_chunk_out;
   logic [SW-1:0] rsp_slot_out;
   logic          rsp_run_last;
   logic          rsp_slot_error;

   release_scoreboard sb = new();

   int             cycle_count = 0;
   int             sent        = 0;
   int             burst_left  = 0;
   bit             req_up      = 1'b0;
   stall_mode_type stall_mode  = STALL_NONE;
   int             stall_hold  = 0;

   ordered_stream_reorder_buffer dut (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_slot_id    (req_slot_id),
      .req_chunk      (req_chunk),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_chunk_out  (rsp_chunk_out),
      .rsp_slot_out   (rsp_slot_out),
      .rsp_run_last   (rsp_run_last),
      .rsp_slot_error (rsp_slot_error)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > MAX_CYCLES) begin
         $display("[ordered_stream_reorder_buffer] ERROR");
         $finish;
      end
   end

   // receiver stall pattern: modes held for random stretches
   always @(posedge clock) begin
      if (stall_hold == 0) begin
         stall_mode <= stall_mode_type'($urandom_range(0, 3));
         stall_hold <= $urandom_range(30, 200);
      end else begin
         stall_hold <= stall_hold - 1;
      end
      case (stall_mode)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
         default:     rsp_stall <= (cycle_count % 3 == 0);
      endcase
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_chunk_out, rsp_slot_out, rsp_run_last, rsp_slot_error);
   end

   function automatic logic [CW-1:0] rand_chunk();
      return {$urandom, $urandom};
   endfunction

   // one insert transfer, then the burst/gap pacing of the sender
   task automatic send_insert(input logic [SW-1:0] slot, input logic [CW-1:0] data);
      int gap;
      req_valid   <= 1'b1;
      req_slot_id <= slot;
      req_chunk   <= data;
      req_up = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_insert(slot, data);
      sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = $urandom_range(1, 10);
         req_valid <= 1'b0;
         req_up = 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = $urandom_range(0, 24);
      end
   endtask

   // hold off until every due release has come out, plus a short tail
   task automatic settle();
      if (req_up) begin
         req_valid <= 1'b0;
         req_up = 1'b0;
      end
      while (sb.due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_length(input logic [SW-1:0] value);
      settle();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      sb.write_length(value);
      csr_we    <= 1'b0;
   endtask

   // one stream: a shuffled or reversed fill of slots 1..len, with stray inserts mixed into shuffled fills
   task automatic run_stream(input logic [SW-1:0] value, input bit reversed,
                             input bit pause_mid);
      int unsigned    len;
      int unsigned    order[$];
      int unsigned    j;
      int unsigned    tmp;
      noise_kind_type kind;
      logic [SW-1:0]  stray;
      write_length(value);
      len = sb.length;
      order.delete();
      for (int unsigned s = 1; s <= len; s++) order = {order, s};
      if (reversed) begin
         order.reverse();
      end else begin
         for (int i = order.size() - 1; i > 0; i--) begin
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
         end
      end
      foreach (order[i]) begin
         if (pause_mid && i == order.size() / 2) settle();
         if (!reversed && $urandom_range(0, 5) == 0) begin
            kind = noise_kind_type'($urandom_range(0, 3));
            case (kind)
               NOISE_ZERO:   stray = '0;
               NOISE_ABOVE:  stray = SW'($urandom_range(len + 1, 127));
               NOISE_REPEAT: stray = SW'($urandom_range(1, len));
               default:      stray = SW'($urandom_range(0, 127));
            endcase
            send_insert(stray, rand_chunk());
         end
         send_insert(SW'(order[i]), rand_chunk());
      end
      // inserts after the stream has finished
      if ($urandom_range(0, 1) == 0)
         send_insert(SW'($urandom_range(0, len + 1)), rand_chunk());
   endtask

   initial begin
      logic [SW-1:0] value;
      bit            first;
      reset       <= 1'b1;
      csr_we      <= 1'b0;
      csr_wdata   <= '0;
      req_valid   <= 1'b0;
      req_slot_id <= '0;
      req_chunk   <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: stream length 64 from reset
      send_insert(7'd2, 64'h0);                    // gap at the pointer, held
      send_insert(7'd0, 64'hFFFF_FFFF_FFFF_FFFF);  // slot zero, never released
      send_insert(7'd1, 64'hA5A5_5A5A_0F0F_F0F0);  // releases 1 and 2
      send_insert(7'd1, 64'h1234_5678_9ABC_DEF0);  // below the pointer
      send_insert(7'd127, 64'hFFFF_FFFF_FFFF_FFFF); // far above the length
      send_insert(7'd65, 64'h0);                   // just above the length
      send_insert(7'd5, 64'h0000_0000_0000_0001);
      send_insert(7'd5, 64'h8000_0000_0000_0000);  // overwrite before release
      send_insert(7'd4, 64'h5555_AAAA_5555_AAAA);
      send_insert(7'd3, 64'hFFFF_FFFF_FFFF_FFFF);  // releases 3, 4, 5
      send_insert(7'd64, 64'hFFFF_FFFF_FFFF_FFFF); // top slot, held

      // length 0 is taken as 1
      write_length(7'd0);
      send_insert(7'd1, 64'hDEAD_BEEF_CAFE_F00D);
      send_insert(7'd1, 64'h0);                    // stream finished
      send_insert(7'd2, 64'h0);                    // above the length
      send_insert(7'd0, 64'h0);

      // length above DEPTH clamps; full stream filled top-down releases all
      run_stream(7'd127, 1'b1, 1'b0);

      // random streams, mostly short
      first = 1'b1;
      while (sent < TARGET_ITEMS) begin
         case ($urandom_range(0, 11))
            0:       value = 7'd64;
            1:       value = 7'd1;
            2:       value = SW'($urandom_range(65, 127));
            default: value = SW'($urandom_range(2, 16));
         endcase
         run_stream(value, (value >= 64) && ($urandom_range(0, 2) == 0), first);
         first = 1'b0;
      end

      settle();
      if (sb.errors == 0)
         $display("[ordered_stream_reorder_buffer] OK");
      else
         $display("[ordered_stream_reorder_buffer] ERROR");
      $finish;
   end

endmodule
